FILE: hdl/lppdc_pkg.sv
// Package: shared constants, config indexes and saturation helpers for the point projector.
`default_nettype none
package lppdc_pkg;

    localparam int unsigned IMAGE_WIDTH_DEF  = 1920;
    localparam int unsigned IMAGE_HEIGHT_DEF = 1080;

    localparam int unsigned DIV_QBITS  = 33;              // quotient bits resolved per lane
    localparam int unsigned DIV_LAT    = DIV_QBITS + 2;   // setup + one bit per stage + sat
    localparam int unsigned DIST_LAT   = 12;
    localparam int unsigned COLOR_LAT  = 3;
    localparam int unsigned PIPE_LAT   = DIV_LAT + DIST_LAT;

    localparam logic signed [31:0] Z_MIN_RAW  = 32'sd6553;
    localparam logic [7:0]         BLUE_LEVEL = 8'd51;
    localparam logic signed [37:0] ONE_Q24    = 38'sd16777216;

    typedef enum logic [2:0] {
        REG_FOCAL_X   = 3'd0,
        REG_FOCAL_Y   = 3'd1,
        REG_CENTER_X  = 3'd2,
        REG_CENTER_Y  = 3'd3,
        REG_K1        = 3'd4,
        REG_K2        = 3'd5,
        REG_K3        = 3'd6,
        REG_INV_DEPTH = 3'd7
    } t_reg_idx;

    localparam logic [31:0] FOCAL_X_RST   = 32'd65536000;
    localparam logic [31:0] FOCAL_Y_RST   = 32'd65536000;
    localparam logic [31:0] CENTER_X_RST  = 32'd62914560;
    localparam logic [31:0] CENTER_Y_RST  = 32'd35389440;
    localparam logic [31:0] INV_DEPTH_RST = 32'd85899346;

    typedef struct packed {
        logic [31:0]        focal_x;
        logic [31:0]        focal_y;
        logic [31:0]        center_x;
        logic [31:0]        center_y;
        logic signed [31:0] k1;
        logic signed [31:0] k2;
        logic signed [31:0] k3;
    } t_cam_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [30:0] usat31(input logic [63:0] v);
        logic [30:0] res;
        if (v > 64'h7FFF_FFFF) begin
            res = 31'h7FFF_FFFF;
        end else begin
            res = v[30:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/lidar_point_projection_depth_color_top.sv
// Top level: lidar point projection with radial distortion and depth color.
//
//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------------
//  point     in         i_valid / o_stall    i_point_x, i_point_y, i_point_z (Q16.16)
//  pixel     out        o_valid / i_stall    o_in_view, o_pixel_u/v, o_color_red/green/blue
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One beat in per clock, one beat out per clock, except while o_stall is high. Points pass
// through the bit-per-stage dividers (x/z and y/z), the distortion/projection stages and
// the output register. All stages share one enable; o_stall rises only while the
// output register holds a beat and i_stall is high. Reset (sync, active low) clears
// the valid bits and loads the register defaults.
`default_nettype none
module lidar_point_projection_depth_color_top #(
    parameter int unsigned IMAGE_WIDTH  = lppdc_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = lppdc_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    input  wire logic signed [31:0] i_point_z,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_in_view,
    output logic [11:0]             o_pixel_u,
    output logic [11:0]             o_pixel_v,
    output logic [7:0]              o_color_red,
    output logic [7:0]              o_color_green,
    output logic [7:0]              o_color_blue,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data
);
    import lppdc_pkg::*;

    localparam int unsigned DLY = PIPE_LAT - COLOR_LAT;

    // config registers
    t_cam_cfg    r_cfg;
    logic [31:0] r_inv_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.focal_x  <= FOCAL_X_RST;
            r_cfg.focal_y  <= FOCAL_Y_RST;
            r_cfg.center_x <= CENTER_X_RST;
            r_cfg.center_y <= CENTER_Y_RST;
            r_cfg.k1       <= '0;
            r_cfg.k2       <= '0;
            r_cfg.k3       <= '0;
            r_inv_depth    <= INV_DEPTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_FOCAL_X:   r_cfg.focal_x  <= i_cfg_data;
                REG_FOCAL_Y:   r_cfg.focal_y  <= i_cfg_data;
                REG_CENTER_X:  r_cfg.center_x <= i_cfg_data;
                REG_CENTER_Y:  r_cfg.center_y <= i_cfg_data;
                REG_K1:        r_cfg.k1       <= i_cfg_data;
                REG_K2:        r_cfg.k2       <= i_cfg_data;
                REG_K3:        r_cfg.k3       <= i_cfg_data;
                REG_INV_DEPTH: r_inv_depth    <= i_cfg_data;
                default:       r_inv_depth    <= r_inv_depth;
            endcase
        end
    end

    // global pipeline enable: move unless the output beat is held
    logic en;
    logic r_ov;
    assign en      = !r_ov || !i_stall;
    assign o_stall = !en;

    // valid bits, one per stage
    logic [PIPE_LAT-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // x/z and y/z lanes
    logic signed [31:0] xn, yn;
    lppdc_div u_div_x (.i_clk, .i_en(en), .i_num(i_point_x), .i_den(i_point_z), .o_quo(xn));
    lppdc_div u_div_y (.i_clk, .i_en(en), .i_num(i_point_y), .i_den(i_point_z), .o_quo(yn));

    logic        in_img;
    logic [11:0] pix_u, pix_v;
    lppdc_dist #(
        .IMAGE_WIDTH (IMAGE_WIDTH),
        .IMAGE_HEIGHT(IMAGE_HEIGHT)
    ) u_dist (
        .i_clk,
        .i_en    (en),
        .i_cfg   (r_cfg),
        .i_xn    (xn),
        .i_yn    (yn),
        .o_in_img(in_img),
        .o_pix_u (pix_u),
        .o_pix_v (pix_v)
    );

    // depth color runs alongside, then waits for the pixel to catch up
    logic       z_ok;
    logic [7:0] red;
    lppdc_color u_color (
        .i_clk,
        .i_en       (en),
        .i_z        (i_point_z),
        .i_inv_depth(r_inv_depth),
        .o_z_ok     (z_ok),
        .o_red      (red)
    );

    logic       r_dly_ok  [0:DLY-1];
    logic [7:0] r_dly_red [0:DLY-1];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_ok[0]  <= z_ok;
            r_dly_red[0] <= red;
            for (int i = 1; i < DLY; i++) begin
                r_dly_ok[i]  <= r_dly_ok[i-1];
                r_dly_red[i] <= r_dly_red[i-1];
            end
        end
    end

    // output register
    logic        hit;
    logic        r_view;
    logic [11:0] r_u, r_v;
    logic [7:0]  r_red, r_green, r_blue;
    assign hit = r_dly_ok[DLY-1] && in_img;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_vld[PIPE_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_view  <= hit;
            r_u     <= hit ? pix_u : '0;
            r_v     <= hit ? pix_v : '0;
            r_red   <= hit ? r_dly_red[DLY-1] : '0;
            r_green <= hit ? 8'(8'd255 - r_dly_red[DLY-1]) : '0;
            r_blue  <= hit ? BLUE_LEVEL : '0;
        end
    end

    assign o_valid       = r_ov;
    assign o_in_view     = r_view;
    assign o_pixel_u     = r_u;
    assign o_pixel_v     = r_v;
    assign o_color_red   = r_red;
    assign o_color_green = r_green;
    assign o_color_blue  = r_blue;
endmodule
`default_nettype wire

FILE: hdl/lppdc_div.sv
// Pipelined restoring divider: (num * 2^24) / den, truncated, saturated to 32 bits.
`default_nettype none
module lppdc_div (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic signed [31:0]      o_quo
);
    import lppdc_pkg::*;

    localparam int unsigned NQ = DIV_QBITS;

    logic [31:0]   r_rem [0:NQ];
    logic [NQ-1:0] r_q   [0:NQ];
    logic [NQ-1:0] r_lo  [0:NQ];
    logic [31:0]   r_den [0:NQ];
    logic          r_neg [0:NQ];
    logic          r_ovf [0:NQ];
    logic signed [31:0] r_quo;

    logic [31:0] mag;
    assign mag = i_num[31] ? (32'd0 - i_num) : i_num;

    // setup: quotient bits above bit 32 are only checked for overflow
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= {9'd0, mag[31:9]};
            r_lo[0]  <= {mag[8:0], 24'd0};
            r_q[0]   <= '0;
            r_den[0] <= i_den;
            r_neg[0] <= i_num[31];
            r_ovf[0] <= ({9'd0, mag[31:9]} >= i_den);
        end
    end

    for (genvar k = 1; k <= NQ; k++) begin : g_step
        logic [32:0] trial;
        logic        ge;
        assign trial = {r_rem[k-1], r_lo[k-1][NQ-1]};
        assign ge    = trial >= {1'b0, r_den[k-1]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? 32'(trial - {1'b0, r_den[k-1]}) : trial[31:0];
                r_q[k]   <= {r_q[k-1][NQ-2:0], ge};
                r_lo[k]  <= {r_lo[k-1][NQ-2:0], 1'b0};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!r_neg[NQ]) begin
                if (r_ovf[NQ] || r_q[NQ] > 33'h0_7FFF_FFFF) begin
                    r_quo <= 32'sh7FFF_FFFF;
                end else begin
                    r_quo <= r_q[NQ][31:0];
                end
            end else begin
                if (r_ovf[NQ] || r_q[NQ] > 33'h0_8000_0000) begin
                    r_quo <= 32'sh8000_0000;
                end else begin
                    r_quo <= 32'd0 - r_q[NQ][31:0];
                end
            end
        end
    end

    assign o_quo = r_quo;
    // r_rem[NQ] is the final remainder; not needed downstream
endmodule
`default_nettype wire

FILE: hdl/lppdc_dist.sv
// Radial distortion, focal scaling and image bounds, twelve register stages.
`default_nettype none
module lppdc_dist #(
    parameter int unsigned IMAGE_WIDTH  = lppdc_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = lppdc_pkg::IMAGE_HEIGHT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire lppdc_pkg::t_cam_cfg i_cfg,
    input  wire logic signed [31:0] i_xn,
    input  wire logic signed [31:0] i_yn,
    output logic                    o_in_img,
    output logic [11:0]             o_pix_u,
    output logic [11:0]             o_pix_v
);
    import lppdc_pkg::*;

    localparam logic signed [41:0] U_LIM = 42'(IMAGE_WIDTH) << 16;
    localparam logic signed [41:0] V_LIM = 42'(IMAGE_HEIGHT) << 16;

    logic signed [31:0] r_xn [1:8];
    logic signed [31:0] r_yn [1:8];
    logic signed [63:0] r_sqx, r_sqy;
    logic [30:0]        r2_r2, r3_r2, r4_r2;
    logic [61:0]        r3_p4, r5_p6;
    logic [30:0]        r4_r4, r6_r6;
    logic signed [63:0] r4_t1, r5_t2, r7_t3;
    logic signed [35:0] r5_t1;
    logic signed [36:0] r6_t12, r7_t12;
    logic signed [31:0] r8_rad;
    logic signed [63:0] r9_mx, r9_my;
    logic signed [31:0] r10_xd, r10_yd;
    logic signed [64:0] r11_pu, r11_pv;
    logic               r12_in;
    logic [11:0]        r12_u, r12_v;

    logic [63:0]        sq_sum;
    logic signed [37:0] rad_sum;
    logic signed [41:0] u_q16, v_q16;

    assign sq_sum  = $unsigned(r_sqx) + $unsigned(r_sqy);
    assign rad_sum = ONE_Q24 + 38'(r7_t12) + 38'(r7_t3 >>> 28);
    assign u_q16   = 42'(r11_pu >>> 24) + $signed({10'd0, i_cfg.center_x});
    assign v_q16   = 42'(r11_pv >>> 24) + $signed({10'd0, i_cfg.center_y});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xn[1] <= i_xn;
            r_yn[1] <= i_yn;
            for (int i = 2; i <= 8; i++) begin
                r_xn[i] <= r_xn[i-1];
                r_yn[i] <= r_yn[i-1];
            end
            // r^2
            r_sqx  <= i_xn * i_xn;
            r_sqy  <= i_yn * i_yn;
            r2_r2  <= usat31(sq_sum >> 24);
            // r^4, k1 term
            r3_p4  <= r2_r2 * r2_r2;
            r3_r2  <= r2_r2;
            r4_r4  <= usat31(64'(r3_p4 >> 24));
            r4_r2  <= r3_r2;
            r4_t1  <= i_cfg.k1 * $signed({1'b0, r3_r2});
            // r^6, k2 term
            r5_p6  <= r4_r4 * r4_r2;
            r5_t2  <= i_cfg.k2 * $signed({1'b0, r4_r4});
            r5_t1  <= 36'(r4_t1 >>> 28);
            r6_r6  <= usat31(64'(r5_p6 >> 24));
            r6_t12 <= 37'(r5_t1) + 37'(r5_t2 >>> 28);
            // k3 term and radial factor
            r7_t3  <= i_cfg.k3 * $signed({1'b0, r6_r6});
            r7_t12 <= r6_t12;
            r8_rad <= sat32(64'(rad_sum));
            // distorted coordinates
            r9_mx  <= r_xn[8] * r8_rad;
            r9_my  <= r_yn[8] * r8_rad;
            r10_xd <= sat32(r9_mx >>> 24);
            r10_yd <= sat32(r9_my >>> 24);
            // pixel space
            r11_pu <= $signed({1'b0, i_cfg.focal_x}) * r10_xd;
            r11_pv <= $signed({1'b0, i_cfg.focal_y}) * r10_yd;
            r12_in <= (u_q16 >= 0) && (u_q16 < U_LIM) && (v_q16 >= 0) && (v_q16 < V_LIM);
            r12_u  <= u_q16[27:16];
            r12_v  <= v_q16[27:16];
        end
    end

    assign o_in_img = r12_in;
    assign o_pix_u  = r12_u;
    assign o_pix_v  = r12_v;
endmodule
`default_nettype wire

FILE: hdl/lppdc_color.sv
// Depth test and depth-to-red mapping, three register stages.
`default_nettype none
module lppdc_color (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic signed [31:0] i_z,
    input  wire logic [31:0]        i_inv_depth,
    output logic                    o_z_ok,
    output logic [7:0]              o_red
);
    import lppdc_pkg::*;

    logic [63:0] r1_prod;
    logic [32:0] r2_norm;
    logic [7:0]  r3_red;
    logic        r1_ok, r2_ok, r3_ok;
    logic [47:0] norm_raw;
    logic [40:0] scaled;

    assign norm_raw = r1_prod[63:16];
    assign scaled   = {r2_norm, 8'd0} - 41'(r2_norm);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_prod <= i_z * i_inv_depth;
            r1_ok   <= i_z > Z_MIN_RAW;
            r2_norm <= (norm_raw > 48'h1_0000_0000) ? 33'h1_0000_0000 : norm_raw[32:0];
            r2_ok   <= r1_ok;
            r3_red  <= scaled[39:32];
            r3_ok   <= r2_ok;
        end
    end

    assign o_z_ok = r3_ok;
    assign o_red  = r3_red;
endmodule
`default_nettype wire

FILE: hdl/lppdc_chk.sv
// Port-level checker for the point projector, with its bind.
`default_nettype none
module lppdc_chk #(
    parameter int unsigned IMAGE_WIDTH  = lppdc_pkg::IMAGE_WIDTH_DEF,
    parameter int unsigned IMAGE_HEIGHT = lppdc_pkg::IMAGE_HEIGHT_DEF
) (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_in_view,
    input wire logic [11:0] o_pixel_u,
    input wire logic [11:0] o_pixel_v,
    input wire logic [7:0]  o_color_red,
    input wire logic [7:0]  o_color_green,
    input wire logic [7:0]  o_color_blue
);
    import lppdc_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_in_view) && $stable(o_pixel_u)
            && $stable(o_color_red))
        else $error("held output beat changed");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a held output beat");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_in_view |-> o_pixel_u == 0 && o_pixel_v == 0 && o_color_red == 0
            && o_color_green == 0 && o_color_blue == 0)
        else $error("out-of-view beat carries data");

    a_hit_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_view |-> o_color_blue == BLUE_LEVEL
            && 9'(o_color_red) + 9'(o_color_green) == 9'd255)
        else $error("depth color inconsistent");

    a_hit_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_in_view |-> 32'(o_pixel_u) < IMAGE_WIDTH
            && 32'(o_pixel_v) < IMAGE_HEIGHT)
        else $error("pixel outside image");
endmodule

bind lidar_point_projection_depth_color_top lppdc_chk #(
    .IMAGE_WIDTH (IMAGE_WIDTH),
    .IMAGE_HEIGHT(IMAGE_HEIGHT)
) u_lppdc_chk (
    .i_clk, .i_rst_n, .o_stall, .o_valid, .i_stall, .o_in_view, .o_pixel_u,
    .o_pixel_v, .o_color_red, .o_color_green, .o_color_blue
);
`default_nettype wire
